// ===== sv/wss_pkg.sv =====
package wss_pkg;

    localparam int DATA_W      = 24;
    localparam int ENTRY_W     = DATA_W + 1;
    localparam int SPIKE_BIT   = DATA_W;
    localparam int COUNT_OUT_W = 7;

    localparam logic [DATA_W-1:0] RESET_THRESHOLD = 24'd1000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVICT,
        S_UPDATE,
        S_SCAN,
        S_DIV,
        S_DONE
    } wss_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic scan_clear;
        logic scan_take;
    } wss_mem_ctrl_t;

endpackage

// ===== sv/windowed_sensor_stats_spike_reject_top.sv =====
// each accepted sample passes eviction, window update, the one-entry-per-cycle min/max scan of
// the filled window entries and the one-bit-per-cycle divider before the result is registered
// one transaction at a time; the next is taken once the result is in the output register,
// even if it has not been taken yet
// reset: window empty, sums and counts zero, threshold 1000; the window memory is not cleared
module windowed_sensor_stats_spike_reject_top #(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [wss_pkg::DATA_W-1:0]            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [wss_pkg::DATA_W-1:0]     sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  spike,
    output logic signed [wss_pkg::DATA_W-1:0]     current_value,
    output logic signed [wss_pkg::DATA_W-1:0]     window_min,
    output logic signed [wss_pkg::DATA_W-1:0]     window_max,
    output logic signed [wss_pkg::DATA_W-1:0]     window_mean,
    output logic [wss_pkg::COUNT_OUT_W-1:0]       good_count
);
    import wss_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = DATA_W + CW;

    localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_AP = AW'(WINDOW_DEPTH - 1);

    wss_state_t state_reg, state_next;

    logic [DATA_W-1:0]        thr_reg;
    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic                     spike_reg, spike_next;
    logic signed [DATA_W-1:0] last_reg, last_next;
    logic                     has_last_reg, has_last_next;
    logic [AW-1:0]            wp_reg, wp_next;
    logic [CW-1:0]            fill_reg, fill_next;
    logic signed [SW-1:0]     sum_reg, sum_next;
    logic [CW-1:0]            total_reg, total_next;
    logic [CW-1:0]            idx_reg, idx_next;
    logic                     take_reg, take_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     out_spike_reg;
    logic signed [DATA_W-1:0] out_cur_reg;
    logic signed [DATA_W-1:0] out_min_reg;
    logic signed [DATA_W-1:0] out_max_reg;
    logic signed [DATA_W-1:0] out_mean_reg;
    logic [COUNT_OUT_W-1:0]   out_count_reg;

    wss_mem_ctrl_t            ctrl;
    logic [AW-1:0]            rd_addr;
    logic [ENTRY_W-1:0]       rd_data;
    logic signed [DATA_W-1:0] win_min;
    logic signed [DATA_W-1:0] win_max;

    logic                     div_start;
    logic                     div_done;
    logic signed [SW-1:0]     div_quo;

    logic                     load_out;
    logic                     out_free;
    logic [DATA_W:0]          diff;
    logic [DATA_W:0]          mag;
    logic [CW+COUNT_OUT_W-1:0] total_ext;

    wss_window #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .AW          (AW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .wr_addr(wp_reg),
        .wr_data({spike_reg, sample_reg}),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .win_min(win_min),
        .win_max(win_max)
    );

    wss_div #(
        .SW(SW),
        .CW(CW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .dividend(sum_reg),
        .divisor (total_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign diff      = {sample_reg[DATA_W-1], sample_reg} - {last_reg[DATA_W-1], last_reg};
    assign mag       = diff[DATA_W] ? (~diff + 1'b1) : diff;
    assign total_ext = {{COUNT_OUT_W{1'b0}}, total_reg};

    always_comb
    begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        spike_next     = spike_reg;
        last_next      = last_reg;
        has_last_next  = has_last_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        idx_next       = idx_reg;
        take_next      = take_reg;
        ctrl           = '0;
        ctrl.scan_take = take_reg;
        rd_addr        = wp_reg;
        div_start      = 1'b0;
        load_out       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // fetch the slot about to be overwritten
                    sample_next = sample;
                    ctrl.rd_en  = 1'b1;
                    state_next  = S_EVICT;
                end
            end
            S_EVICT:
            begin
                spike_next = has_last_reg && (mag > {1'b0, thr_reg});
                if (fill_reg == DEPTH_C && !rd_data[SPIKE_BIT] && total_reg != '0)
                begin
                    sum_next   = sum_reg - {{CW{rd_data[DATA_W-1]}}, rd_data[DATA_W-1:0]};
                    total_next = total_reg - 1'b1;
                end
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                ctrl.wr_en      = 1'b1;
                ctrl.scan_clear = 1'b1;
                if (!spike_reg)
                begin
                    sum_next      = sum_reg + {{CW{sample_reg[DATA_W-1]}}, sample_reg};
                    total_next    = total_reg + 1'b1;
                    last_next     = sample_reg;
                    has_last_next = 1'b1;
                end
                wp_next = (wp_reg == LAST_AP) ? '0 : wp_reg + 1'b1;
                if (fill_reg != DEPTH_C)
                begin
                    fill_next = fill_reg + 1'b1;
                end
                idx_next   = '0;
                take_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (idx_reg < fill_reg)
                begin
                    ctrl.rd_en = 1'b1;
                    rd_addr    = idx_reg[AW-1:0];
                    idx_next   = idx_reg + 1'b1;
                    take_next  = 1'b1;
                end
                else
                begin
                    take_next = 1'b0;
                    // wait for the last read to be folded in
                    if (!take_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            thr_reg       <= RESET_THRESHOLD;
            has_last_reg  <= 1'b0;
            last_reg      <= '0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            take_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            has_last_reg  <= has_last_next;
            last_reg      <= last_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            idx_reg       <= idx_next;
            take_reg      <= take_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        spike_reg  <= spike_next;
        if (load_out)
        begin
            out_spike_reg <= spike_reg;
            out_cur_reg   <= sample_reg;
            out_min_reg   <= win_min;
            out_max_reg   <= win_max;
            out_mean_reg  <= (total_reg == '0) ? '0 : div_quo[DATA_W-1:0];
            out_count_reg <= total_ext[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign spike         = out_spike_reg;
    assign current_value = out_cur_reg;
    assign window_min    = out_min_reg;
    assign window_max    = out_max_reg;
    assign window_mean   = out_mean_reg;
    assign good_count    = out_count_reg;

    a_accept_to_evict: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_EVICT)
        else $error("accepted transaction did not start eviction");

    a_total_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= fill_reg)
        else $error("valid count exceeds window fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("window fill beyond depth");

    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DIV || $past(state_reg) == S_DONE)
        else $error("result raised outside of division completion");

    a_scan_addr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && ctrl.rd_en |-> idx_reg < fill_reg)
        else $error("scan read beyond filled entries");

endmodule

// ===== sv/wss_window.sv =====
module wss_window #(
    parameter int WINDOW_DEPTH = 64,
    parameter int AW           = 6
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wss_pkg::wss_mem_ctrl_t         ctrl,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [wss_pkg::ENTRY_W-1:0]    wr_data,
    input  logic [AW-1:0]                  rd_addr,
    output logic [wss_pkg::ENTRY_W-1:0]    rd_data,
    output logic signed [wss_pkg::DATA_W-1:0] win_min,
    output logic signed [wss_pkg::DATA_W-1:0] win_max
);
    import wss_pkg::*;

    logic [ENTRY_W-1:0] mem [WINDOW_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic                     any_reg, any_next;
    logic signed [DATA_W-1:0] min_reg, min_next;
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] entry_val;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign entry_val = $signed(rd_data_reg[DATA_W-1:0]);

    // fold one scanned entry into the running min and max
    always_comb
    begin
        any_next = any_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (ctrl.scan_clear)
        begin
            any_next = 1'b0;
        end
        else if (ctrl.scan_take && !rd_data_reg[SPIKE_BIT])
        begin
            any_next = 1'b1;
            if (!any_reg || entry_val < min_reg)
            begin
                min_next = entry_val;
            end
            if (!any_reg || entry_val > max_reg)
            begin
                max_next = entry_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            any_reg <= 1'b0;
        end
        else
        begin
            any_reg <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign win_min = any_reg ? min_reg : '0;
    assign win_max = any_reg ? max_reg : '0;

endmodule

// ===== sv/wss_div.sv =====
module wss_div #(
    parameter int SW = 31,
    parameter int CW = 7
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [CW-1:0]        divisor,
    output logic                 done,
    output logic signed [SW-1:0] quotient
);
    import wss_pkg::*;

    localparam int NW = $clog2(SW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          neg_reg, neg_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] quo_reg, quo_next;
    logic [CW-1:0] div_reg, div_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW:0]   rem_shift;
    logic [CW:0]   rem_sub;

    // restoring division on magnitudes, one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        rem_shift = {rem_reg, quo_reg[SW-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SW-1];
            quo_next  = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = NW'(SW);
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, div_reg})
            begin
                rem_next = rem_sub[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[CW-1:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(-quo_reg) : $signed(quo_reg);

endmodule
